@@ rtl/core/banknote_serial_check_unit_assert.svh @@
// assertion macros for the banknote serial check unit
`ifndef BANKNOTE_SERIAL_CHECK_UNIT_ASSERT_SVH
`define BANKNOTE_SERIAL_CHECK_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bsc_pkg.sv @@
// shared types, constants, character and check-digit functions for the serial check unit
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned SeriesW = 2;
  localparam int unsigned CountW  = 4;
  localparam int unsigned ResW    = 4;
  localparam int unsigned ValW    = 5;
  localparam int unsigned SumW    = 6;

  localparam logic [CharW-1:0] Char0 = 8'h30;
  localparam logic [CharW-1:0] Char9 = 8'h39;
  localparam logic [CharW-1:0] CharA = 8'h41;
  localparam logic [CharW-1:0] CharZ = 8'h5A;

  localparam logic [CountW-1:0] SerialLength = 4'd12;
  localparam logic [CountW-1:0] CountLimit   = 4'd13;
  localparam logic [CountW-1:0] LastSumPos   = 4'd10;
  localparam logic [CountW-1:0] CheckPos     = 4'd11;
  localparam logic [CountW-1:0] Pos0         = 4'd0;
  localparam logic [CountW-1:0] Pos1         = 4'd1;
  localparam logic [CountW-1:0] Pos3         = 4'd3;

  localparam logic [SumW-1:0] Mod9x1 = 6'd9;
  localparam logic [SumW-1:0] Mod9x2 = 6'd18;
  localparam logic [SumW-1:0] Mod9x3 = 6'd27;

  localparam logic [ResW-1:0] Base2002   = 4'd8;
  localparam logic [ResW-1:0] Base2013   = 4'd7;
  localparam logic [ResW-1:0] ResSeven   = 4'd7;
  localparam logic [ResW-1:0] ResEight   = 4'd8;
  localparam logic [ValW-1:0] ZeroSubst  = 5'd9;
  localparam logic [ValW-1:0] MinusSubst = 5'd8;

  typedef enum logic [SeriesW-1:0] {
    SERIES_INVALID = 2'd0,
    SERIES_2002    = 2'd1,
    SERIES_2013    = 2'd2
  } series_t;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             is_last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic [SeriesW-1:0] series;
    logic               check_2002_ok;
    logic               check_2013_ok;
  } result_t;

  function automatic logic is_capital(input logic [CharW-1:0] c);
    return c inside {[CharA:CharZ]};
  endfunction

  function automatic logic [ValW-1:0] char_value(input logic [CharW-1:0] c);
    logic [CharW-1:0] d;
    d = '0;
    if (c inside {[Char0:Char9]}) begin
      d = c - Char0;
    end else if (c inside {[CharA:CharZ]}) begin
      d = c - CharA + 8'd1;
    end
    return d[ValW-1:0];
  endfunction

  // residue below 9 plus value below 27 stays below 36
  function automatic logic [ResW-1:0] add_mod9(input logic [ResW-1:0] r,
                                               input logic [ValW-1:0] v);
    logic [SumW-1:0] s;
    s = {2'b00, r} + {1'b0, v};
    if (s >= Mod9x3) begin
      s = s - Mod9x3;
    end else if (s >= Mod9x2) begin
      s = s - Mod9x2;
    end else if (s >= Mod9x1) begin
      s = s - Mod9x1;
    end
    return s[ResW-1:0];
  endfunction

  function automatic logic [ValW-1:0] expect_2002(input logic [ResW-1:0] r);
    logic [ResW-1:0] e;
    e = Base2002 - r;
    return (r == ResEight) ? ZeroSubst : {1'b0, e};
  endfunction

  function automatic logic [ValW-1:0] expect_2013(input logic [ResW-1:0] r);
    logic [ResW-1:0] e;
    e = Base2013 - r;
    if (r == ResSeven) begin
      return ZeroSubst;
    end else if (r == ResEight) begin
      return MinusSubst;
    end
    return {1'b0, e};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/bsc_in_if.sv @@
// input channel: one serial character per item
`timescale 1ns / 1ps
`default_nettype none

interface bsc_in_if;
  logic                      valid;
  logic                      ready;
  logic [bsc_pkg::CharW-1:0] char_code;
  logic                      is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink (input valid, input char_code, input is_last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bsc_out_if.sv @@
// result channel: series and both check outcomes per item
`timescale 1ns / 1ps
`default_nettype none

interface bsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [bsc_pkg::SeriesW-1:0] series;
  logic                        check_2002_ok;
  logic                        check_2013_ok;

  modport source (output valid, output series, output check_2002_ok,
                  output check_2013_ok, input ready);
  modport sink (input valid, input series, input check_2002_ok,
                input check_2013_ok, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bsc_in_stage.sv @@
// input register that captures one character item per cycle unless it is held full by a core stall
`timescale 1ns / 1ps
`default_nettype none

module bsc_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  bsc_in_if.sink          in_ch,
  input  logic            core_ready,
  output bsc_pkg::stage_t s1
);
  import bsc_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  assign in_ch.ready = !valid_r || core_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (core_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (take) begin
      item_r.char_code <= in_ch.char_code;
      item_r.is_last   <= in_ch.is_last;
    end
  end

  assign s1.valid = valid_r;
  assign s1.item  = item_r;

endmodule

`default_nettype wire

@@ rtl/core/bsc_core.sv @@
// running serial state, series/check evaluation and result register
`timescale 1ns / 1ps
`default_nettype none

module bsc_core (
  input  logic            clk,
  input  logic            rst_n,
  input  bsc_pkg::stage_t s1,
  output logic            core_ready,
  bsc_out_if.source       out_ch
);
  import bsc_pkg::*;

  logic [CountW-1:0] pos_r, pos_nxt, pos_upd;
  logic [ResW-1:0]   res_r, res_nxt, res_upd;
  logic [2:0]        flags_r, flags_nxt, flags_upd;
  logic [ValW-1:0]   check_r, check_nxt, check_upd;
  logic              out_valid_r, out_valid_nxt;
  result_t           result_r, result_nxt;
  logic [ValW-1:0]   v;
  logic              letter;
  logic              take;
  series_t           series;

  assign core_ready = !out_valid_r || out_ch.ready;
  assign take       = s1.valid && core_ready;
  assign v          = char_value(s1.item.char_code);
  assign letter     = is_capital(s1.item.char_code);

  always_comb begin
    pos_upd   = pos_r;
    res_upd   = res_r;
    flags_upd = flags_r;
    check_upd = check_r;
    if (pos_r <= LastSumPos) begin
      res_upd = add_mod9(res_r, v);
    end
    if (letter && pos_r == Pos0) begin
      flags_upd[0] = 1'b1;
    end
    if (letter && pos_r == Pos1) begin
      flags_upd[1] = 1'b1;
    end
    if (letter && pos_r == Pos3) begin
      flags_upd[2] = 1'b1;
    end
    if (pos_r == CheckPos) begin
      check_upd = v;
    end
    if (pos_r < CountLimit) begin
      pos_upd = pos_r + 4'd1;
    end

    series = SERIES_INVALID;
    result_nxt.check_2002_ok = 1'b0;
    result_nxt.check_2013_ok = 1'b0;
    if (pos_upd == SerialLength) begin
      if (!flags_upd[0]) begin
        series = SERIES_INVALID;
      end else if (!flags_upd[1]) begin
        series = SERIES_2002;
      end else if (flags_upd[2]) begin
        series = SERIES_INVALID;
      end else begin
        series = SERIES_2013;
      end
      result_nxt.check_2002_ok = (expect_2002(res_upd) == check_upd);
      result_nxt.check_2013_ok = (expect_2013(res_upd) == check_upd);
    end
    result_nxt.series = series;

    // the last character of a serial clears the state for the next one
    if (s1.item.is_last) begin
      pos_nxt   = '0;
      res_nxt   = '0;
      flags_nxt = '0;
      check_nxt = '0;
    end else begin
      pos_nxt   = pos_upd;
      res_nxt   = res_upd;
      flags_nxt = flags_upd;
      check_nxt = check_upd;
    end

    out_valid_nxt = out_valid_r;
    if (take && s1.item.is_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      res_r       <= '0;
      flags_r     <= '0;
      check_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        pos_r   <= pos_nxt;
        res_r   <= res_nxt;
        flags_r <= flags_nxt;
        check_r <= check_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
    if (take && s1.item.is_last) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.series        = result_r.series;
  assign out_ch.check_2002_ok = result_r.check_2002_ok;
  assign out_ch.check_2013_ok = result_r.check_2013_ok;

endmodule

`default_nettype wire

@@ rtl/core/banknote_serial_check_unit.sv @@
// top level of the banknote serial number check unit
`timescale 1ns / 1ps
`default_nettype none
`include "banknote_serial_check_unit_assert.svh"

// Checks euro banknote serial numbers fed one ASCII character per item, with
// is_last set on the final character. A character is taken every cycle as long
// as the result side keeps up; only the last character of a serial produces a
// result item (series plus both check flags). A character passes an input
// register and then one update/evaluation step into the result register, which
// presents the result. Throughput is one character per cycle while the result
// side keeps up, as the mod-9 state update is combinational; a stalled result
// holds the pipe only once both registers are full.

module banknote_serial_check_unit (
  input  logic       clk,
  input  logic       rst_n,
  bsc_in_if.sink     in_ch,
  bsc_out_if.source  out_ch
);
  import bsc_pkg::*;

  stage_t s1;
  logic   core_ready;

  bsc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .core_ready (core_ready),
    .s1         (s1)
  );

  bsc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1         (s1),
    .core_ready (core_ready),
    .out_ch     (out_ch)
  );

  // a stalled input side means the input register holds an item
  `BSC_ASSERT_NOW(a_stall_has_item, !in_ch.ready, s1.valid, "input stall with empty stage")
  // a last character leaving the input stage always lands in the result register
  `BSC_ASSERT_NEXT(a_last_gives_result, s1.valid && s1.item.is_last && core_ready, out_ch.valid, "last item lost")
  // the two check rules never expect the same character value
  `BSC_ASSERT_NOW(a_checks_exclusive, out_ch.valid, !(out_ch.check_2002_ok && out_ch.check_2013_ok), "both checks pass")
  // the series code 3 is never produced
  `BSC_ASSERT_NOW(a_series_code, out_ch.valid, out_ch.series != 2'd3, "bad series code")

endmodule

`default_nettype wire

@@ tb/tb_banknote_serial_check_unit.sv @@
// self-checking testbench for the banknote serial number check unit
`timescale 1ns / 1ps

module tb_banknote_serial_check_unit;
  import bsc_pkg::*;

  localparam int RandomItems = 900;
  localparam int PhaseItems  = 300;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 10;
  localparam int CycleLimit  = 200000;

  typedef struct packed {
    series_t series;
    logic    ok_2002;
    logic    ok_2013;
  } verdict_t;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             is_last;
    logic             typed;
    verdict_t         want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  bsc_in_if  in_if ();
  bsc_out_if out_if ();

  banknote_serial_check_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expectation typed into the directed rows, carried alongside the item
  logic     cur_typed;
  verdict_t cur_want;

  int send_idle_pct;
  int recv_idle_pct;
  int stress_phase;
  int hold_left;
  logic hold_done;

  int cycle_count;
  int fail_count;
  int items_sent;
  int serials_checked;
  int series_tally [3];
  int hits_2002;
  int hits_2013;

  stim_row_t directed_rows [$];
  verdict_t  pending_verdicts [$];

  // serial state of the predictor
  logic [CountW-1:0] seen_count;
  logic [ResW-1:0]   digit_residue;
  logic [2:0]        letter_marks;
  logic [ValW-1:0]   check_weight;

  function automatic logic is_letter(input logic [CharW-1:0] c);
    return (c >= CharA) && (c <= CharZ);
  endfunction

  function automatic int char_weight(input logic [CharW-1:0] c);
    if ((c >= Char0) && (c <= Char9)) begin
      return int'(c) - int'(Char0);
    end
    if (is_letter(c)) begin
      return int'(c) - int'(CharA) + 1;
    end
    return 0;
  endfunction

  function automatic void note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  task automatic advance_serial(input logic [CharW-1:0] c, input logic last,
                                output logic done, output verdict_t v);
    int w;
    int r;
    int e_old;
    int e_new;
    w = char_weight(c);
    if (seen_count <= LastSumPos) begin
      digit_residue = ResW'((int'(digit_residue) + w) % 9);
    end
    if (seen_count == Pos0 && is_letter(c)) letter_marks[0] = 1'b1;
    if (seen_count == Pos1 && is_letter(c)) letter_marks[1] = 1'b1;
    if (seen_count == Pos3 && is_letter(c)) letter_marks[2] = 1'b1;
    if (seen_count == CheckPos) check_weight = ValW'(w);
    if (seen_count < CountLimit) seen_count = seen_count + 1'b1;
    done = last;
    v.series  = SERIES_INVALID;
    v.ok_2002 = 1'b0;
    v.ok_2013 = 1'b0;
    if (last) begin
      if (seen_count == SerialLength) begin
        if (!letter_marks[0]) begin
          v.series = SERIES_INVALID;
        end else if (!letter_marks[1]) begin
          v.series = SERIES_2002;
        end else if (letter_marks[2]) begin
          v.series = SERIES_INVALID;
        end else begin
          v.series = SERIES_2013;
        end
        r = int'(digit_residue);
        // zero check digit is written as nine, minus one as eight
        e_old = (r == 8) ? 9 : 8 - r;
        e_new = (r == 7) ? 9 : ((r == 8) ? 8 : 7 - r);
        v.ok_2002 = (e_old == int'(check_weight));
        v.ok_2013 = (e_new == int'(check_weight));
      end
      seen_count    = '0;
      digit_residue = '0;
      letter_marks  = '0;
      check_weight  = '0;
    end
  endtask

  always @(posedge clk) begin : in_monitor
    logic     done;
    verdict_t v;
    if (!rst_n) begin
      seen_count    = '0;
      digit_residue = '0;
      letter_marks  = '0;
      check_weight  = '0;
    end else if (in_if.valid && in_if.ready) begin
      advance_serial(in_if.char_code, in_if.is_last, done, v);
      if (done) begin
        pending_verdicts.push_back(cur_typed ? cur_want : v);
      end
    end
  end

  always @(posedge clk) begin : out_monitor
    verdict_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        note_fail($sformatf("unexpected result: series %0d 2002 %0b 2013 %0b",
                            out_if.series, out_if.check_2002_ok, out_if.check_2013_ok));
      end else begin
        want = pending_verdicts.pop_front();
        serials_checked++;
        series_tally[want.series]++;
        if (want.ok_2002) hits_2002++;
        if (want.ok_2013) hits_2013++;
        if (out_if.series !== want.series || out_if.check_2002_ok !== want.ok_2002 ||
            out_if.check_2013_ok !== want.ok_2013) begin
          note_fail($sformatf(
            "serial %0d: expected series %0d 2002 %0b 2013 %0b, got %0d %0b %0b",
            serials_checked, want.series, want.ok_2002, want.ok_2013,
            out_if.series, out_if.check_2002_ok, out_if.check_2013_ok));
        end
      end
    end
  end

  // result side: random stalls plus one long hold-off at the start of the last phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (stress_phase == 2 && !hold_done) begin
      out_if.ready <= 1'b0;
      hold_left    <= HoldCycles;
      hold_done    <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_verdicts.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(input logic [CharW-1:0] c, input logic last,
                           input logic typed, input verdict_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= c;
    in_if.is_last   <= last;
    cur_typed       <= typed;
    cur_want        <= want;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic put_row(input logic [CharW-1:0] c, input logic last, input logic typed,
                         input series_t ser, input logic ok_old, input logic ok_new);
    stim_row_t row;
    row.char_code    = c;
    row.is_last      = last;
    row.typed        = typed && last;
    row.want.series  = ser;
    row.want.ok_2002 = ok_old;
    row.want.ok_2013 = ok_new;
    directed_rows.push_back(row);
  endtask

  task automatic put_text(input string s, input logic typed, input series_t ser,
                          input logic ok_old, input logic ok_new);
    for (int k = 0; k < s.len(); k++) begin
      put_row(s[k], k == s.len() - 1, typed, ser, ok_old, ok_new);
    end
  endtask

  // mostly well-formed serials, with noise characters and odd lengths mixed in
  task automatic send_serial();
    int len;
    int pick;
    int acc;
    int r;
    int e;
    logic [CharW-1:0] c;
    verdict_t none;
    none = '0;
    len = ($urandom_range(99) < 75) ? 12 : int'($urandom_range(16, 1));
    acc = 0;
    for (int k = 0; k < len; k++) begin
      pick = int'($urandom_range(99));
      if (k == 11 && pick < 70) begin
        // aim the check character at one of the two rules
        r = acc;
        if ($urandom_range(1)) begin
          e = (r == 8) ? 9 : 8 - r;
        end else begin
          e = (r == 7) ? 9 : ((r == 8) ? 8 : 7 - r);
        end
        c = CharW'($urandom_range(1) ? int'(Char0) + e : int'(CharA) + e - 1);
      end else if (pick < 8) begin
        c = CharW'($urandom_range(255));
      end else if ((k == 0 && pick < 90) || ((k == 1 || k == 3) && pick < 55) || pick < 20) begin
        c = CharA + CharW'($urandom_range(25));
      end else begin
        c = Char0 + CharW'($urandom_range(9));
      end
      if (k <= 10) acc = (acc + char_weight(c)) % 9;
      send_item(c, k == len - 1, 1'b0, none);
    end
  endtask

  initial begin
    int directed_count;
    int random_sent;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.char_code = '0;
    in_if.is_last   = 1'b0;
    out_if.ready    = 1'b0;
    cur_typed       = 1'b0;
    cur_want        = '0;
    send_idle_pct   = 8;
    recv_idle_pct   = 85;
    stress_phase    = 0;
    cycle_count     = 0;
    fail_count      = 0;
    items_sent      = 0;
    serials_checked = 0;
    series_tally    = '{0, 0, 0};
    hits_2002       = 0;
    hits_2013       = 0;

    // extreme codes as one-character serials, a well-formed serial with a
    // lowercase character inside, and a serial one character too long
    put_row(8'hFF, 1'b1, 1'b1, SERIES_INVALID, 1'b0, 1'b0);
    put_row(8'h00, 1'b1, 1'b1, SERIES_INVALID, 1'b0, 1'b0);
    put_text("UAz123456788", 1'b0, SERIES_INVALID, 1'b0, 1'b0);
    put_text("ABCDEFGHIJKLM", 1'b1, SERIES_INVALID, 1'b0, 1'b0);
    directed_count = directed_rows.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      send_item(directed_rows[k].char_code, directed_rows[k].is_last,
                directed_rows[k].typed, directed_rows[k].want);
    end

    random_sent = 0;
    while (random_sent < RandomItems) begin
      if (random_sent < PhaseItems) begin
        send_idle_pct = 8;
        recv_idle_pct <= 85;
        stress_phase  <= 0;
      end else if (random_sent < 2 * PhaseItems) begin
        send_idle_pct = 85;
        recv_idle_pct <= 8;
        stress_phase  <= 1;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        stress_phase  <= 2;
      end
      send_serial();
      random_sent = items_sent - directed_count;
    end
    in_if.valid <= 1'b0;

    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("%0d characters sent, %0d serials checked: %0d rejected, %0d of 2002, %0d of 2013",
             items_sent, serials_checked, series_tally[0], series_tally[1], series_tally[2]);
    $display("check character matches: %0d on the 2002 rule, %0d on the 2013 rule, %0d errors",
             hits_2002, hits_2013, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ banknote_serial_check_unit.f @@
+incdir+rtl/core
rtl/core/bsc_pkg.sv
rtl/core/bsc_in_if.sv
rtl/core/bsc_out_if.sv
rtl/core/bsc_in_stage.sv
rtl/core/bsc_core.sv
rtl/core/banknote_serial_check_unit.sv
tb/tb_banknote_serial_check_unit.sv
